@@ hdl/wpsu_pkg.sv @@
// ----------------------------------------------------------------------------
// wpsu_pkg
// Shared types and constants for the WAV PCM sample unpacker.
// ----------------------------------------------------------------------------
package wpsu_pkg;

  localparam logic [5:0]  HDR_BYTES   = 6'd44;
  localparam logic [15:0] PCM_FORMAT  = 16'd1;
  localparam logic [15:0] WIDE_BITS   = 16'd16;
  localparam logic [15:0] NARROW_BITS = 16'd8;
  localparam logic [15:0] STEREO_CH   = 16'd2;
  localparam logic [7:0]  BYTE_OFFSET = 8'd128;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_BAD_TAG   = 3'd2;
  localparam logic [2:0] ST_NOT_PCM   = 3'd3;
  localparam logic [2:0] ST_BAD_DEPTH = 3'd4;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;  // "RIFF", first char low
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;  // "WAVE", first char low

  localparam int OUT_TDATA_W = 104;

  typedef struct packed {
    logic        done;
    logic        hvalid;
    logic [2:0]  stop;
    logic [31:0] rate;
    logic [15:0] chans;
    logic [15:0] bits;
    logic [31:0] len;
  } hdr_info_t;

  typedef struct packed {
    logic zero_pair;
    logic eof;
  } hdr_evt_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] left;
    logic [15:0] right;
  } smp_t;

  function automatic logic [15:0] widen8(input logic [7:0] b);
    widen8 = {b ^ BYTE_OFFSET, 8'h00};
  endfunction

endpackage

@@ hdl/wpsu_hdr.sv @@
// ----------------------------------------------------------------------------
// wpsu_hdr
// Canonical 44-byte RIFF header parser: tag checks, field capture, status.
// ----------------------------------------------------------------------------
module wpsu_hdr (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          byte_in,
  input  logic                file_end,
  output wpsu_pkg::hdr_info_t hdr_cur,
  output wpsu_pkg::hdr_info_t hdr_nxt,
  output wpsu_pkg::hdr_evt_t  evt
);
  import wpsu_pkg::*;

  logic [5:0]  cnt_r, cnt_nxt;
  logic        tags_r, tags_nxt;
  logic [15:0] fmt_r, fmt_nxt;
  logic [15:0] chans_r, chans_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [31:0] len_r, len_nxt;
  logic [2:0]  stop_r, stop_nxt;
  logic        done_r;
  logic [7:0]  tag_byte;

  assign done_r = (cnt_r == HDR_BYTES);

  always_comb begin
    cnt_nxt   = cnt_r;
    tags_nxt  = tags_r;
    fmt_nxt   = fmt_r;
    chans_nxt = chans_r;
    rate_nxt  = rate_r;
    bits_nxt  = bits_r;
    len_nxt   = len_r;
    stop_nxt  = stop_r;
    evt       = '0;
    tag_byte  = (cnt_r < 6'd4) ? TAG_RIFF[{cnt_r[1:0], 3'b000} +: 8]
                               : TAG_WAVE[{cnt_r[1:0], 3'b000} +: 8];
    if (step && !done_r) begin
      if (cnt_r < 6'd4 || (cnt_r >= 6'd8 && cnt_r < 6'd12)) begin
        if (byte_in != tag_byte) tags_nxt = 1'b0;
      end else if (cnt_r == 6'd20 || cnt_r == 6'd21) begin
        fmt_nxt[{cnt_r[0], 3'b000} +: 8] = byte_in;
      end else if (cnt_r == 6'd22 || cnt_r == 6'd23) begin
        chans_nxt[{cnt_r[0], 3'b000} +: 8] = byte_in;
      end else if (cnt_r >= 6'd24 && cnt_r < 6'd28) begin
        rate_nxt[{cnt_r[1:0], 3'b000} +: 8] = byte_in;
      end else if (cnt_r == 6'd34 || cnt_r == 6'd35) begin
        bits_nxt[{cnt_r[0], 3'b000} +: 8] = byte_in;
      end else if (cnt_r >= 6'd40) begin
        len_nxt[{cnt_r[1:0], 3'b000} +: 8] = byte_in;
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_nxt == HDR_BYTES) begin
        if (!tags_nxt) begin
          stop_nxt = ST_BAD_TAG;
        end else if (fmt_nxt != PCM_FORMAT) begin
          stop_nxt = ST_NOT_PCM;
        end else if (len_nxt != 32'd0 && bits_nxt != WIDE_BITS &&
                     bits_nxt != NARROW_BITS) begin
          stop_nxt      = ST_BAD_DEPTH;
          evt.zero_pair = 1'b1;
        end else if (file_end) begin
          evt.eof = 1'b1;
        end
      end else if (file_end) begin
        stop_nxt = ST_SHORT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      tags_r  <= 1'b1;
      fmt_r   <= '0;
      chans_r <= '0;
      rate_r  <= '0;
      bits_r  <= '0;
      len_r   <= '0;
      stop_r  <= ST_OK;
    end else begin
      cnt_r   <= cnt_nxt;
      tags_r  <= tags_nxt;
      fmt_r   <= fmt_nxt;
      chans_r <= chans_nxt;
      rate_r  <= rate_nxt;
      bits_r  <= bits_nxt;
      len_r   <= len_nxt;
      stop_r  <= stop_nxt;
    end
  end

  assign hdr_cur.done   = done_r;
  assign hdr_cur.hvalid = done_r && tags_r && (fmt_r == PCM_FORMAT);
  assign hdr_cur.stop   = stop_r;
  assign hdr_cur.rate   = rate_r;
  assign hdr_cur.chans  = chans_r;
  assign hdr_cur.bits   = bits_r;
  assign hdr_cur.len    = len_r;

  assign hdr_nxt.done   = (cnt_nxt == HDR_BYTES);
  assign hdr_nxt.hvalid = (cnt_nxt == HDR_BYTES) && tags_nxt && (fmt_nxt == PCM_FORMAT);
  assign hdr_nxt.stop   = stop_nxt;
  assign hdr_nxt.rate   = rate_nxt;
  assign hdr_nxt.chans  = chans_nxt;
  assign hdr_nxt.bits   = bits_nxt;
  assign hdr_nxt.len    = len_nxt;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= HDR_BYTES)
    else $error("header count past header length");

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> done_r)
    else $error("header done dropped");

  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && stop_r != ST_OK) |=> $stable(stop_r))
    else $error("stop code changed after stop");

endmodule

@@ hdl/wpsu_data.sv @@
// ----------------------------------------------------------------------------
// wpsu_data
// Data section: byte position tracking and little-endian frame assembly.
// ----------------------------------------------------------------------------
module wpsu_data (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          byte_in,
  input  logic                file_end,
  input  wpsu_pkg::hdr_info_t hdr_cur,
  input  wpsu_pkg::hdr_info_t hdr_nxt,
  input  wpsu_pkg::hdr_evt_t  evt,
  output wpsu_pkg::smp_t      smp,
  output logic                data_done
);
  import wpsu_pkg::*;

  logic [31:0] pos_r, pos_nxt, pos_inc;
  logic [1:0]  fidx_r, fidx_nxt;
  logic [23:0] fbytes_r, fbytes_nxt;
  logic        stereo, wide, active, frame_end;
  logic [2:0]  flen;
  logic [31:0] full;

  assign stereo    = (hdr_cur.chans == STEREO_CH);
  assign wide      = (hdr_cur.bits == WIDE_BITS);
  assign flen      = wide ? (stereo ? 3'd4 : 3'd2) : (stereo ? 3'd2 : 3'd1);
  assign active    = step && hdr_cur.done && (hdr_cur.stop == ST_OK) &&
                     (pos_r < hdr_cur.len);
  assign frame_end = ({1'b0, fidx_r} + 3'd1) >= flen;
  assign full      = {8'h00, fbytes_r} | ({24'h0, byte_in} << {fidx_r, 3'b000});
  assign pos_inc   = pos_r + 32'd1;

  always_comb begin
    pos_nxt    = pos_r;
    fidx_nxt   = fidx_r;
    fbytes_nxt = fbytes_r;
    smp        = '0;
    if (evt.eof) begin
      pos_nxt = hdr_nxt.len;
    end else if (active) begin
      pos_nxt = pos_inc;
      if (frame_end) begin
        smp.valid = 1'b1;
        if (wide) begin
          smp.left  = full[15:0];
          smp.right = stereo ? full[31:16] : full[15:0];
        end else begin
          smp.left  = widen8(full[7:0]);
          smp.right = stereo ? widen8(full[15:8]) : widen8(full[7:0]);
        end
        fidx_nxt   = 2'd0;
        fbytes_nxt = '0;
      end else begin
        fidx_nxt   = fidx_r + 2'd1;
        fbytes_nxt = full[23:0];
      end
      if (pos_inc >= hdr_cur.len || file_end) begin
        pos_nxt    = hdr_cur.len;
        fidx_nxt   = 2'd0;
        fbytes_nxt = '0;
      end
    end
  end

  assign data_done = pos_nxt >= hdr_nxt.len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      fidx_r   <= '0;
      fbytes_r <= '0;
    end else begin
      pos_r    <= pos_nxt;
      fidx_r   <= fidx_nxt;
      fbytes_r <= fbytes_nxt;
    end
  end

  a_no_data_before_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    !hdr_cur.done |-> (fidx_r == 2'd0))
    else $error("frame bytes collected during header");

  a_idx_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_cur.done |-> ({1'b0, fidx_r} < flen))
    else $error("frame index beyond frame length");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_cur.done |-> (pos_r <= hdr_cur.len))
    else $error("data position past data length");

endmodule

@@ hdl/wav_pcm_sample_unpacker.sv @@
// ----------------------------------------------------------------------------
// wav_pcm_sample_unpacker
// From input request to result request: input register, then result register.
// Throughput: one byte per cycle, one result each, while out_tready takes results.
// Header parse and frame assembly are single-pass logic between the two.
// Reset (rst_n low, synchronous) clears parser state and both valid flags.
// ----------------------------------------------------------------------------
module wav_pcm_sample_unpacker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [7:0]                           in_tdata,   // byte_in
  input  logic                                 in_tlast,   // file_end
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // left_sample[15:0], right_sample[31:16], sample_valid[32], header_valid[33],
  // status[36:34], finished[37], header_rate[69:38], channel_count[85:70],
  // sample_bits[101:86], zero pad[103:102]
  output logic [wpsu_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import wpsu_pkg::*;

  logic                   in_valid_r;
  logic [7:0]             byte_r;
  logic                   last_r;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                   out_free, go;
  logic                   data_done, fin;
  hdr_info_t              hdr_cur, hdr_nxt;
  hdr_evt_t               evt;
  smp_t                   smp;

  assign out_free  = !out_valid_r || out_tready;
  assign go        = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (go) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

  wpsu_hdr u_hdr (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (go),
    .byte_in  (byte_r),
    .file_end (last_r),
    .hdr_cur  (hdr_cur),
    .hdr_nxt  (hdr_nxt),
    .evt      (evt)
  );

  wpsu_data u_data (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (go),
    .byte_in   (byte_r),
    .file_end  (last_r),
    .hdr_cur   (hdr_cur),
    .hdr_nxt   (hdr_nxt),
    .evt       (evt),
    .smp       (smp),
    .data_done (data_done)
  );

  assign fin = (hdr_nxt.stop != ST_OK) || (hdr_nxt.done && data_done);

  assign out_data_nxt = {2'b00, hdr_nxt.bits, hdr_nxt.chans, hdr_nxt.rate, fin,
                         hdr_nxt.stop, hdr_nxt.hvalid, smp.valid || evt.zero_pair,
                         smp.right, smp.left};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_no_step_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !go)
    else $error("result overwritten while stalled");

  a_sample_needs_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    go && (smp.valid || evt.zero_pair) |-> hdr_nxt.hvalid)
    else $error("sample produced without valid header");

  a_err_finished: assert property (@(posedge clk) disable iff (!rst_n)
    go && (hdr_nxt.stop != ST_OK) |-> fin)
    else $error("error status without finished");

  a_one_source: assert property (@(posedge clk) disable iff (!rst_n)
    !(smp.valid && evt.zero_pair))
    else $error("frame sample and zero pair together");

endmodule
